@@ design/nnim_pkg.sv @@
// ----------------------------------------------------------------------------
// nnim_pkg
// Shared types and register indexes for the nearest-neighbor index map.
// ----------------------------------------------------------------------------
package nnim_pkg;

  localparam int CFG_IDX_BITS = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_IN_WIDTH   = 2'd0;
  localparam cfg_idx_t REG_IN_HEIGHT  = 2'd1;
  localparam cfg_idx_t REG_OUT_WIDTH  = 2'd2;
  localparam cfg_idx_t REG_OUT_HEIGHT = 2'd3;

endpackage

@@ design/nnim_cfg.sv @@
// ----------------------------------------------------------------------------
// nnim_cfg
// Size registers. Each written value is stored already limited to the
// range 1 to 2^DIM_BITS, so the datapath never sees a zero or oversized plane.
// ----------------------------------------------------------------------------
module nnim_cfg #(
  parameter int DIM_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  nnim_pkg::cfg_idx_t   cfg_addr,
  input  logic [DIM_BITS:0]    cfg_data,
  output logic [DIM_BITS:0]    in_width,
  output logic [DIM_BITS:0]    in_height,
  output logic [DIM_BITS:0]    out_width,
  output logic [DIM_BITS:0]    out_height
);

  import nnim_pkg::*;

  localparam logic [DIM_BITS:0] SIZE_ONE = (DIM_BITS+1)'(1);
  localparam logic [DIM_BITS:0] SIZE_MAX = SIZE_ONE << DIM_BITS;

  logic [DIM_BITS:0] size_eff;

  always_comb begin
    if (cfg_data == '0) begin
      size_eff = SIZE_ONE;
    end else if (cfg_data > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= SIZE_ONE;
      in_height  <= SIZE_ONE;
      out_width  <= SIZE_ONE;
      out_height <= SIZE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IN_WIDTH:   in_width   <= size_eff;
        REG_IN_HEIGHT:  in_height  <= size_eff;
        REG_OUT_WIDTH:  out_width  <= size_eff;
        REG_OUT_HEIGHT: out_height <= size_eff;
      endcase
    end
  end

endmodule

@@ design/nnim_lane.sv @@
// ----------------------------------------------------------------------------
// nnim_lane
// One coordinate axis: clamp, scale by the source size, then a restoring
// divider by the output size that resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module nnim_lane #(
  parameter int DIM_BITS = 13
) (
  input  logic                  clk,
  input  logic [DIM_BITS-1:0]   pos,
  input  logic [DIM_BITS:0]     src_size,
  input  logic [DIM_BITS:0]     dst_size,
  output logic [DIM_BITS-1:0]   coord
);

  import nnim_pkg::*;

  localparam int W = DIM_BITS;

  logic [W-1:0]   pos_clamp;
  logic [2*W-1:0] prod;
  logic [W:0]     rem  [1:W];
  logic [W-1:0]   lq   [1:W];

  always_ff @(posedge clk) begin
    if ({1'b0, pos} >= dst_size) begin
      pos_clamp <= W'(dst_size - (W+1)'(1));
    end else begin
      pos_clamp <= pos;
    end
  end

  always_ff @(posedge clk) begin
    prod <= (2*W)'(pos_clamp * src_size);
  end

  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0]   rem_in;
    logic [W-1:0] lq_in;
    logic [W+1:0] trial;
    logic [W+1:0] diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, prod[2*W-1:W]};
      assign lq_in  = prod[W-1:0];
    end else begin : g_next
      assign rem_in = rem[k];
      assign lq_in  = lq[k];
    end

    assign trial = {rem_in, lq_in[W-1]};
    assign ge    = trial >= {1'b0, dst_size};
    assign diff  = trial - {1'b0, dst_size};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[W:0] : trial[W:0];
      lq[k+1]  <= {lq_in[W-2:0], ge};
    end
  end

  assign coord = lq[W];

endmodule

@@ design/nearest_neighbor_index_map_core.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_index_map_core
// Maps an output pixel position to the source pixel that fills it under
// nearest-neighbor scaling: src = floor(pos * in_size / out_size).
//
//   Channel   Ports                               Handshake
//   command   start, busy, out_row, out_col       start high, busy low
//   result    done, src_row, src_col              done high for one cycle
//   config    cfg_we, cfg_addr, cfg_data          cfg_we high, no wait
//
// A word is accepted in every cycle that busy is low, and its result
// passes through the stages in order: one stage clamps, one multiplies,
// and the divider resolves one quotient bit in each of DIM_BITS stages.
// Busy is high only during reset, which clears the valid bits and sets
// all sizes to 1. The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module nearest_neighbor_index_map_core #(
  parameter int DIM_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [DIM_BITS-1:0]  out_row,
  input  logic [DIM_BITS-1:0]  out_col,
  output logic                 done,
  output logic [DIM_BITS-1:0]  src_row,
  output logic [DIM_BITS-1:0]  src_col,
  input  logic                 cfg_we,
  input  nnim_pkg::cfg_idx_t   cfg_addr,
  input  logic [DIM_BITS:0]    cfg_data
);

  import nnim_pkg::*;

  localparam int LAT = DIM_BITS + 2;

  logic [DIM_BITS:0] in_width;
  logic [DIM_BITS:0] in_height;
  logic [DIM_BITS:0] out_width;
  logic [DIM_BITS:0] out_height;
  logic [LAT-1:0]    vld;

  assign busy = rst;

  nnim_cfg #(.DIM_BITS(DIM_BITS)) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_width   (in_width),
    .in_height  (in_height),
    .out_width  (out_width),
    .out_height (out_height)
  );

  nnim_lane #(.DIM_BITS(DIM_BITS)) u_row (
    .clk      (clk),
    .pos      (out_row),
    .src_size (in_height),
    .dst_size (out_height),
    .coord    (src_row)
  );

  nnim_lane #(.DIM_BITS(DIM_BITS)) u_col (
    .clk      (clk),
    .pos      (out_col),
    .src_size (in_width),
    .dst_size (out_width),
    .coord    (src_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

endmodule

@@ dv/nearest_neighbor_index_map_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_neighbor_index_map_core_tb
// Self-checking bench for the nearest-neighbor index map. A queue of pixel
// requests feeds a clocked driver with random idle bursts. The driver predicts
// the source pixel of each accepted word from its own copy of the plane sizes.
// A clocked monitor compares each done word with the oldest prediction. The
// run sweeps sizes from the reset values through identity, extreme up and
// down scaling, a halving, zero and oversized registers, and random planes.
// ----------------------------------------------------------------------------
module nearest_neighbor_index_map_core_tb;

  import nnim_pkg::*;

  localparam int DIM_BITS = 13;
  localparam int LATENCY  = DIM_BITS + 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [DIM_BITS:0] DIM_MAX = 14'd8192;

  typedef logic [DIM_BITS-1:0] coord_t;
  typedef logic [DIM_BITS:0]   dim_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   start = 1'b0;
  logic   busy;
  coord_t out_row = '0;
  coord_t out_col = '0;
  logic   done;
  coord_t src_row;
  coord_t src_col;
  logic   cfg_we;
  cfg_idx_t cfg_addr;
  dim_t   cfg_data;

  dim_t in_w = 14'd1;
  dim_t in_h = 14'd1;
  dim_t out_w = 14'd1;
  dim_t out_h = 14'd1;

  pixel_t req_q[$];
  pixel_t src_q[$];
  pixel_t next_req;
  pixel_t want;
  int     gap_left = 0;
  bit     calm = 1'b0;
  int     mismatches = 0;
  int     idle_cycles = 0;

  nearest_neighbor_index_map_core #(.DIM_BITS(DIM_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .out_row(out_row),
    .out_col(out_col),
    .done(done),
    .src_row(src_row),
    .src_col(src_col),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic dim_t eff_dim(dim_t v);
    if (v == '0) begin
      return 14'd1;
    end
    if (v > DIM_MAX) begin
      return DIM_MAX;
    end
    return v;
  endfunction

  function automatic coord_t scale_coord(coord_t pos, dim_t src_sz, dim_t dst_sz);
    logic [31:0] s;
    logic [31:0] d;
    logic [31:0] p;
    s = 32'(eff_dim(src_sz));
    d = 32'(eff_dim(dst_sz));
    p = 32'(pos);
    if (p > d - 1) begin
      p = d - 1;
    end
    return coord_t'((p * s) / d);
  endfunction

  function automatic pixel_t map_pixel(coord_t r, coord_t c);
    pixel_t px;
    px.row = scale_coord(r, in_h, out_h);
    px.col = scale_coord(c, in_w, out_w);
    return px;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        src_q.push_back(map_pixel(out_row, out_col));
        if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 7);
        end
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (req_q.size() > 0) begin
        next_req = req_q.pop_front();
        start <= 1'b1;
        out_row <= next_req.row;
        out_col <= next_req.col;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (src_q.size() == 0) begin
        $error("unexpected result word: src_row=%0d src_col=%0d", src_row, src_col);
        mismatches++;
      end else begin
        want = src_q.pop_front();
        if (src_row !== want.row) begin
          $error("src_row: expected %0d, actual %0d", want.row, src_row);
          mismatches++;
        end
        if (src_col !== want.col) begin
          $error("src_col: expected %0d, actual %0d", want.col, src_col);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, dim_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_WIDTH: begin
        in_w = val;
      end
      REG_IN_HEIGHT: begin
        in_h = val;
      end
      REG_OUT_WIDTH: begin
        out_w = val;
      end
      default: begin
        out_h = val;
      end
    endcase
  endtask

  task automatic set_dims(dim_t iw, dim_t ih, dim_t ow, dim_t oh);
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    @(negedge clk);
  endtask

  task automatic queue_px(coord_t r, coord_t c);
    req_q.push_back('{row: r, col: c});
  endtask

  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || start || src_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic dim_t rand_dim();
    case ($urandom_range(0, 5))
      0: return dim_t'($urandom_range(1, 16));
      1: return dim_t'($urandom_range(8000, 8192));
      2: return 14'd0;
      3: return dim_t'($urandom_range(8193, 16383));
      default: return dim_t'($urandom_range(1, 8192));
    endcase
  endfunction

  task automatic queue_random(int n);
    int rmax;
    int cmax;
    rmax = int'(eff_dim(out_h)) - 1;
    cmax = int'(eff_dim(out_w)) - 1;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_px(coord_t'($urandom), coord_t'($urandom));
      end else begin
        queue_px(coord_t'($urandom_range(0, rmax)), coord_t'($urandom_range(0, cmax)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_IN_WIDTH;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (busy) begin
      @(negedge clk);
    end

    queue_px(13'd0, 13'd0);
    queue_px(13'd8191, 13'd8191);
    queue_px(13'd1, 13'd0);
    queue_px(13'd0, 13'd8191);
    drain();

    set_dims(14'd8192, 14'd8192, 14'd8192, 14'd8192);
    queue_px(13'd0, 13'd0);
    queue_px(13'd8191, 13'd8191);
    queue_px(13'd4096, 13'd1);
    queue_px(13'd1, 13'd4096);
    queue_px(13'h1555, 13'h0aaa);
    drain();

    set_dims(14'd8192, 14'd1, 14'd1, 14'd8192);
    queue_px(13'd8191, 13'd8191);
    queue_px(13'd0, 13'd0);
    queue_px(13'd100, 13'd5);
    drain();

    set_dims(14'd640, 14'd480, 14'd320, 14'd240);
    queue_px(13'd239, 13'd319);
    queue_px(13'd240, 13'd320);
    queue_px(13'd8191, 13'd8191);
    queue_px(13'd0, 13'd0);
    drain();

    set_dims(14'd16383, 14'd0, 14'd8193, 14'd5);
    queue_px(13'd8191, 13'd8191);
    queue_px(13'd3, 13'd77);
    queue_px(13'd6, 13'd0);
    drain();

    set_dims(14'd3, 14'd10000, 14'd0, 14'd7);
    queue_px(13'd6, 13'd8191);
    queue_px(13'd100, 13'd1);
    queue_px(13'd2, 13'd2);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_dims(rand_dim(), rand_dim(), rand_dim(), rand_dim());
      calm = (ph == 9);
      queue_random(55);
      drain();
    end

    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
